// ===== sv/lcdcur_pkg.sv =====
// Shared types, codes and helpers for the character display cursor controller.
`default_nettype none

package lcdcur_pkg;

  typedef enum logic [2:0] {
    FN_WRITE_CHAR = 3'd0,
    FN_CLEAR      = 3'd1,
    FN_CLEAR_EOL  = 3'd2,
    FN_UP         = 3'd3,
    FN_DOWN       = 3'd4,
    FN_LEFT       = 3'd5,
    FN_RIGHT      = 3'd6,
    FN_SET_POS    = 3'd7
  } func_t;

  // What the first beat of a command is followed by
  typedef enum logic [1:0] {
    LK_DATA  = 2'd0,  // data beat, then address beat
    LK_FINAL = 2'd1,  // single beat ends the command
    LK_SPACE = 2'd2   // run of spaces, then address beat
  } lead_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEAD = 2'd1,
    ST_ADDR = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic emit_lead;
    logic emit_addr;
  } dp_cmd_t;

  typedef struct packed {
    lead_kind_t lead_kind;
    logic       cnt_zero;
    logic       out_free;
  } dp_stat_t;

  localparam logic [7:0] DDRAM_SET   = 8'h80;
  localparam logic [7:0] LINE2_BASE  = 8'h40;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] CLEAR_INSTR = 8'h01;
  localparam logic [7:0] PRINT_LO0   = 8'h20;
  localparam logic [7:0] PRINT_HI0   = 8'h7F;
  localparam logic [7:0] PRINT_LO1   = 8'hA0;
  localparam logic [7:0] PRINT_HI1   = 8'hFE;

  // Set-address instruction for a cursor on the given line and column (1-based)
  function automatic logic [7:0] addr_byte(input logic line2, input logic [7:0] col);
    addr_byte = DDRAM_SET | ((line2 ? LINE2_BASE : 8'h00) + (col - 8'd1));
  endfunction

endpackage

`default_nettype wire

// ===== sv/lcdcur_ctrl.sv =====
// Controller: sequences the beats of one command.
`default_nettype none

module lcdcur_ctrl
  import lcdcur_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output dp_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.emit_lead = 1'b0;
    cmd.emit_addr = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (stat.out_free) begin
          cmd.emit_lead = 1'b1;
          case (stat.lead_kind)
            LK_DATA:  state_nxt = ST_ADDR;
            LK_SPACE: state_nxt = stat.cnt_zero ? ST_ADDR : ST_LEAD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADDR: begin
        if (stat.out_free) begin
          cmd.emit_addr = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lcdcur_dp.sv =====
// Datapath: cursor, latched command, space counter and result register.
`default_nettype none

module lcdcur_dp
  import lcdcur_pkg::*;
#(
  parameter int LINE_LENGTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [2:0] in_func,
  input  wire logic [7:0] in_char_code,
  input  wire logic [1:0] in_target_row,
  input  wire logic [4:0] in_target_column,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_write_valid,
  output logic            out_register_select,
  output logic [7:0]      out_bus_byte,
  output logic            out_ok,
  output logic [1:0]      out_cursor_row,
  output logic [4:0]      out_cursor_column,
  output logic            out_last
);

  localparam int COL_W = $clog2(LINE_LENGTH + 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_LENGTH);
  localparam logic [COL_W-1:0] FIRST_COL = COL_W'(1);

  // latched command
  func_t            func_r;
  logic [7:0]       char_r;
  logic [1:0]       trow_r;
  logic [4:0]       tcol_r;

  // cursor: line2_r selects line two, col_r is 1..LINE_LENGTH
  logic             line2_r, line2_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] cnt_r, cnt_nxt;

  logic             ov_r, ov_nxt;
  logic             wv_r, rs_r, ok_r, last_r, row2_r;
  logic [7:0]       byte_r;
  logic [COL_W-1:0] ocol_r;

  // first-beat plan for the latched command
  lead_kind_t       kind;
  logic             new_line2;
  logic [COL_W-1:0] new_col;
  logic             ld_wv, ld_rs, ld_ok;
  logic [7:0]       ld_byte;
  logic             printable, set_ok, out_free;

  assign out_free = !ov_r || out_ready;

  assign printable = (char_r inside {[PRINT_LO0:PRINT_HI0], [PRINT_LO1:PRINT_HI1]});
  assign set_ok    = (tcol_r != 5'd0) && (8'(tcol_r) <= 8'(LINE_LENGTH))
                   && (trow_r == 2'd1 || trow_r == 2'd2);

  always_comb begin
    kind      = LK_FINAL;
    new_line2 = line2_r;
    new_col   = col_r;
    ld_wv     = 1'b0;
    ld_rs     = 1'b0;
    ld_ok     = 1'b0;
    ld_byte   = 8'h00;
    case (func_r)
      FN_WRITE_CHAR: begin
        if (printable) begin
          kind    = LK_DATA;
          ld_wv   = 1'b1;
          ld_rs   = 1'b1;
          ld_ok   = 1'b1;
          ld_byte = char_r;
          if (col_r == LAST_COL) begin
            new_line2 = !line2_r;
            new_col   = FIRST_COL;
          end else begin
            new_col = col_r + FIRST_COL;
          end
        end
      end
      FN_CLEAR: begin
        ld_wv     = 1'b1;
        ld_ok     = 1'b1;
        ld_byte   = CLEAR_INSTR;
        new_line2 = 1'b0;
        new_col   = FIRST_COL;
      end
      FN_CLEAR_EOL: begin
        kind    = LK_SPACE;
        ld_wv   = 1'b1;
        ld_rs   = 1'b1;
        ld_ok   = 1'b1;
        ld_byte = SPACE_CHAR;
      end
      FN_UP: begin
        if (line2_r) begin
          ld_ok     = 1'b1;
          new_line2 = 1'b0;
        end
      end
      FN_DOWN: begin
        if (!line2_r) begin
          ld_ok     = 1'b1;
          new_line2 = 1'b1;
        end
      end
      FN_LEFT: begin
        if (col_r != FIRST_COL) begin
          ld_ok   = 1'b1;
          new_col = col_r - FIRST_COL;
        end else if (line2_r) begin
          ld_ok     = 1'b1;
          new_line2 = 1'b0;
          new_col   = LAST_COL;
        end
      end
      FN_RIGHT: begin
        if (col_r != LAST_COL) begin
          ld_ok   = 1'b1;
          new_col = col_r + FIRST_COL;
        end else if (!line2_r) begin
          ld_ok     = 1'b1;
          new_line2 = 1'b1;
          new_col   = FIRST_COL;
        end
      end
      FN_SET_POS: begin
        if (set_ok) begin
          ld_ok     = 1'b1;
          new_line2 = (trow_r == 2'd2);
          new_col   = COL_W'(tcol_r);
        end
      end
      default: ;
    endcase
    // accepted moves write the new address in their only beat
    if (func_r inside {FN_UP, FN_DOWN, FN_LEFT, FN_RIGHT, FN_SET_POS} && ld_ok) begin
      ld_wv   = 1'b1;
      ld_byte = addr_byte(new_line2, 8'(new_col));
    end
  end

  assign stat.lead_kind = kind;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      char_r <= in_char_code;
      trow_r <= in_target_row;
      tcol_r <= in_target_column;
    end
  end

  always_comb begin
    line2_nxt = line2_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    if (cmd.load) begin
      cnt_nxt = LAST_COL - col_r;
    end
    if (cmd.emit_lead) begin
      line2_nxt = new_line2;
      col_nxt   = new_col;
      if (kind == LK_SPACE && cnt_r != '0) begin
        cnt_nxt = cnt_r - FIRST_COL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line2_r <= 1'b0;
      col_r   <= FIRST_COL;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      line2_r <= line2_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.emit_lead || cmd.emit_addr) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // result register; every beat reports the cursor after the command
  always_ff @(posedge clk) begin
    if (cmd.emit_lead) begin
      wv_r   <= ld_wv;
      rs_r   <= ld_rs;
      byte_r <= ld_byte;
      ok_r   <= ld_ok;
      last_r <= (kind == LK_FINAL);
      row2_r <= new_line2;
      ocol_r <= new_col;
    end else if (cmd.emit_addr) begin
      wv_r   <= 1'b1;
      rs_r   <= 1'b0;
      byte_r <= addr_byte(line2_r, 8'(col_r));
      ok_r   <= 1'b1;
      last_r <= 1'b1;
      row2_r <= line2_r;
      ocol_r <= col_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_write_valid     = wv_r;
  assign out_register_select = rs_r;
  assign out_bus_byte        = byte_r;
  assign out_ok              = ok_r;
  assign out_last            = last_r;
  assign out_cursor_row      = row2_r ? 2'd2 : 2'd1;
  assign out_cursor_column   = 5'(ocol_r);

endmodule

`default_nettype wire

// ===== sv/char_lcd_cursor_controller_core.sv =====
// Sequencing: an accepted command is latched, and its first result beat is loaded into the result
// register once that register is free. Throughput: one command at a time; one result beat per cycle
// from the single result register when the consumer keeps out_ready high.
// Reset: synchronous active-low rst_n puts the cursor at line one, column one, idle.
// Top level: command controller plus cursor datapath.
`default_nettype none

module char_lcd_cursor_controller_core
  import lcdcur_pkg::*;
#(
  parameter int LINE_LENGTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_func,
  input  wire logic [7:0] in_char_code,
  input  wire logic [1:0] in_target_row,
  input  wire logic [4:0] in_target_column,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_write_valid,
  output logic            out_register_select,
  output logic [7:0]      out_bus_byte,
  output logic            out_ok,
  output logic [1:0]      out_cursor_row,
  output logic [4:0]      out_cursor_column,
  output logic            out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lcdcur_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcdcur_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_target_row       (in_target_row),
    .in_target_column    (in_target_column),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_write_valid     (out_write_valid),
    .out_register_select (out_register_select),
    .out_bus_byte        (out_bus_byte),
    .out_ok              (out_ok),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_column   (out_cursor_column),
    .out_last            (out_last)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while previous one still in flight");

  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_lead && cmd.emit_addr))
    else $error("two result beats loaded in one cycle");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_lead || cmd.emit_addr) |-> stat.out_free)
    else $error("result register overwritten before the beat was taken");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_row == 2'd1 || out_cursor_row == 2'd2))
    else $error("cursor row out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/char_lcd_cursor_controller_core_test.sv =====
// Self-checking testbench for the character display cursor controller core.
module char_lcd_cursor_controller_core_test;
  import lcdcur_pkg::*;

  localparam int LINE_LEN     = 16;
  localparam int RANDOM_CMDS  = 445;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic RS_INSTR   = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef struct packed {
    func_t      fn;
    logic [7:0] ch;
    logic [1:0] row;
    logic [4:0] col;
  } lcd_cmd_t;

  typedef struct packed {
    logic       write_valid;
    logic       reg_sel;
    logic [7:0] bus_byte;
    logic       ok;
    logic [1:0] row;
    logic [4:0] col;
    logic       last;
  } lcd_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_func;
  logic [7:0] in_char_code;
  logic [1:0] in_target_row;
  logic [4:0] in_target_column;
  logic       out_valid;
  logic       out_ready;
  logic       out_write_valid;
  logic       out_register_select;
  logic [7:0] out_bus_byte;
  logic       out_ok;
  logic [1:0] out_cursor_row;
  logic [4:0] out_cursor_column;
  logic       out_last;

  char_lcd_cursor_controller_core #(.LINE_LENGTH(LINE_LEN)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_char_code        (in_char_code),
    .in_target_row       (in_target_row),
    .in_target_column    (in_target_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_write_valid     (out_write_valid),
    .out_register_select (out_register_select),
    .out_bus_byte        (out_bus_byte),
    .out_ok              (out_ok),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_column   (out_cursor_column),
    .out_last            (out_last)
  );

  lcd_cmd_t  pending_cmds[$];
  lcd_beat_t expected_writes[$];
  logic [5:0] cursor_addr;
  int errors;
  int in_beats;
  int cmds_total;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lcd_beat_t bus_write(input logic rs, input logic [7:0] value);
    lcd_beat_t b;
    b = '0;
    b.write_valid = 1'b1;
    b.reg_sel = rs;
    b.bus_byte = value;
    return b;
  endfunction

  function automatic logic [7:0] ddram_byte(input logic [5:0] a);
    if (a <= LINE_LEN) return DDRAM_SET | 8'(a - 1);
    return DDRAM_SET | 8'(LINE2_BASE + a - LINE_LEN - 1);
  endfunction

  // Work out the display writes of one command and advance the cursor copy.
  task automatic predict_cursor_cmd(input func_t fn, input logic [7:0] ch,
                                    input logic [1:0] trow, input logic [4:0] tcol);
    lcd_beat_t writes[$];
    lcd_beat_t b;
    logic accepted;
    int stop_addr;
    accepted = 1'b0;
    case (fn)
      FN_WRITE_CHAR: begin
        if ((ch >= PRINT_LO0 && ch <= PRINT_HI0) || (ch >= PRINT_LO1 && ch <= PRINT_HI1)) begin
          writes.push_back(bus_write(RS_DATA, ch));
          cursor_addr = (cursor_addr == 2 * LINE_LEN) ? 6'd1 : cursor_addr + 6'd1;
          writes.push_back(bus_write(RS_INSTR, ddram_byte(cursor_addr)));
          accepted = 1'b1;
        end
      end
      FN_CLEAR: begin
        writes.push_back(bus_write(RS_INSTR, CLEAR_INSTR));
        cursor_addr = 6'd1;
        accepted = 1'b1;
      end
      FN_CLEAR_EOL: begin
        stop_addr = (cursor_addr <= LINE_LEN) ? LINE_LEN : 2 * LINE_LEN;
        for (int a = cursor_addr; a <= stop_addr; a++)
          writes.push_back(bus_write(RS_DATA, SPACE_CHAR));
        writes.push_back(bus_write(RS_INSTR, ddram_byte(cursor_addr)));
        accepted = 1'b1;
      end
      FN_UP: begin
        if (cursor_addr > LINE_LEN) begin
          cursor_addr = 6'(cursor_addr - LINE_LEN);
          accepted = 1'b1;
        end
      end
      FN_DOWN: begin
        if (cursor_addr <= LINE_LEN) begin
          cursor_addr = 6'(cursor_addr + LINE_LEN);
          accepted = 1'b1;
        end
      end
      FN_LEFT: begin
        if (cursor_addr > 1) begin
          cursor_addr = cursor_addr - 6'd1;
          accepted = 1'b1;
        end
      end
      FN_RIGHT: begin
        if (cursor_addr < 2 * LINE_LEN) begin
          cursor_addr = cursor_addr + 6'd1;
          accepted = 1'b1;
        end
      end
      default: begin
        if (tcol >= 1 && tcol <= LINE_LEN && (trow == 2'd1 || trow == 2'd2)) begin
          cursor_addr = (trow == 2'd1) ? 6'(tcol) : 6'(tcol + LINE_LEN);
          accepted = 1'b1;
        end
      end
    endcase
    // moves and set position only write the new address
    if (accepted && fn inside {FN_UP, FN_DOWN, FN_LEFT, FN_RIGHT, FN_SET_POS})
      writes.push_back(bus_write(RS_INSTR, ddram_byte(cursor_addr)));
    if (writes.size() == 0) begin
      b = '0;
      writes.push_back(b);
    end
    foreach (writes[i]) begin
      b = writes[i];
      b.ok = accepted;
      b.row = (cursor_addr <= LINE_LEN) ? 2'd1 : 2'd2;
      b.col = (cursor_addr <= LINE_LEN) ? 5'(cursor_addr) : 5'(cursor_addr - LINE_LEN);
      b.last = (i == writes.size() - 1);
      expected_writes.push_back(b);
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic queue_cmd(input func_t fn, input logic [7:0] ch,
                           input logic [1:0] row, input logic [4:0] col);
    lcd_cmd_t c;
    c.fn = fn;
    c.ch = ch;
    c.row = row;
    c.col = col;
    pending_cmds.push_back(c);
  endtask

  // Monitor: predict on accepted commands, check accepted result beats.
  always @(posedge clk) begin
    lcd_beat_t e;
    if (!rst_n) begin
      cursor_addr = 6'd1;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected result beat: bus_byte 0x%0h", out_bus_byte);
          errors++;
        end else begin
          e = expected_writes.pop_front();
          check_field("write_valid", e.write_valid, out_write_valid);
          check_field("register_select", e.reg_sel, out_register_select);
          check_field("bus_byte", e.bus_byte, out_bus_byte);
          check_field("ok", e.ok, out_ok);
          check_field("cursor_row", e.row, out_cursor_row);
          check_field("cursor_column", e.col, out_cursor_column);
          check_field("last", e.last, out_last);
        end
      end
      if (in_valid && in_ready) begin
        predict_cursor_cmd(func_t'(in_func), in_char_code, in_target_row, in_target_column);
        in_beats <= in_beats + 1;
      end
    end
  end

  // Driver: bursts of commands separated by random gaps.
  int sent;
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    lcd_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_beats < sent)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_func <= c.fn;
        in_char_code <= c.ch;
        in_target_row <= c.row;
        in_target_column <= c.col;
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
  int rx_mode;
  int rx_left;
  int hold_left;
  logic hold_done;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && in_beats >= 60) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycle_count % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    lcd_cmd_t c;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_CLEAR;
    in_char_code = '0;
    in_target_row = '0;
    in_target_column = '0;
    out_ready = 1'b0;
    errors = 0;
    in_beats = 0;
    sent = 0;
    burst_left = 8;
    gap_left = 0;
    rx_mode = 0;
    rx_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    cycle_count = 0;
    cursor_addr = 6'd1;

    // Directed: rejected moves at the edges, printable bounds, bad positions,
    // wrap from the last cell, clear to end of line on both lines.
    queue_cmd(FN_CLEAR, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_LEFT, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_UP, 8'hFF, 2'd3, 5'd31);
    queue_cmd(FN_WRITE_CHAR, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h1F, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h20, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h7F, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h80, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h9F, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'hA0, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'hFE, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'hFF, 2'd3, 5'd31);
    queue_cmd(FN_SET_POS, 8'h00, 2'd0, 5'd1);
    queue_cmd(FN_SET_POS, 8'h00, 2'd3, 5'd5);
    queue_cmd(FN_SET_POS, 8'h00, 2'd1, 5'd0);
    queue_cmd(FN_SET_POS, 8'h00, 2'd1, 5'd17);
    queue_cmd(FN_SET_POS, 8'h00, 2'd2, 5'd31);
    queue_cmd(FN_SET_POS, 8'h00, 2'd2, 5'd16);
    queue_cmd(FN_RIGHT, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_WRITE_CHAR, 8'h41, 2'd0, 5'd0);
    queue_cmd(FN_DOWN, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_CLEAR_EOL, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_UP, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_CLEAR_EOL, 8'h00, 2'd0, 5'd0);
    queue_cmd(FN_SET_POS, 8'h00, 2'd1, 5'd16);
    queue_cmd(FN_CLEAR_EOL, 8'h00, 2'd0, 5'd0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      c.ch = 8'($urandom);
      c.row = 2'($urandom);
      c.col = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) c.fn = FN_WRITE_CHAR;
      else if (pick < 40) c.fn = FN_CLEAR;
      else if (pick < 48) c.fn = FN_CLEAR_EOL;
      else if (pick < 56) c.fn = FN_UP;
      else if (pick < 64) c.fn = FN_DOWN;
      else if (pick < 74) c.fn = FN_LEFT;
      else if (pick < 84) c.fn = FN_RIGHT;
      else begin
        c.fn = FN_SET_POS;
        // mostly legal positions so the cursor roams the whole display
        if ($urandom_range(0, 3) != 0) begin
          c.row = 2'($urandom_range(1, 2));
          c.col = 5'($urandom_range(1, LINE_LEN));
        end
      end
      pending_cmds.push_back(c);
    end
    cmds_total = pending_cmds.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (in_beats < cmds_total || expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_writes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
